// ----- hdl/ecspm_pkg.sv -----
// Shared types, constants and micro-program for the EC scalar point multiplier.
// Depends on nothing; used by ecspm_dp, ecspm_ctrl and ec_scalar_point_multiply.
`default_nettype none

package ecspm_pkg;

  localparam int unsigned WordBits = 16;

  typedef struct packed {
    logic [WordBits-1:0] base_x;
    logic [WordBits-1:0] base_y;
    logic [WordBits-1:0] scalar;
  } in_word_t;

  typedef struct packed {
    logic [WordBits-1:0] result_x;
    logic [WordBits-1:0] result_y;
    logic                at_infinity;
    logic                inverse_error;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_RED, OP_MOV, OP_MVR, OP_LDK, OP_LDP,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP
  } op_t;

  // R_QSX / R_QSY name the current addend; the controller maps them.
  typedef enum logic [3:0] {
    R_X1, R_Y1, R_QX, R_QY, R_A, R_NUM, R_DEN, R_LAM,
    R_TMP, R_U, R_V, R_T0, R_T1, R_Q, R_QSX, R_QSY
  } reg_t;

  typedef enum logic [1:0] {EXT_X, EXT_Y, EXT_A} ext_t;

  typedef struct packed {
    op_t  op;
    reg_t dst;
    reg_t s1;
    reg_t s2;
    ext_t ext;
    logic k;
  } uop_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic a_zero;
    logic a_one;
  } dp_stat_t;

  typedef logic [5:0] upc_t;

  localparam upc_t PC_INIT        = 6'd0;
  localparam upc_t PC_LAST_INIT   = 6'd2;
  localparam upc_t PC_ADD_INF     = 6'd3;
  localparam upc_t PC_ADD_INF_END = 6'd4;
  localparam upc_t PC_CMP_X       = 6'd5;
  localparam upc_t PC_CMP_Y       = 6'd6;
  localparam upc_t PC_DBL_END     = 6'd11;
  localparam upc_t PC_ADD         = 6'd12;
  localparam upc_t PC_INV         = 6'd14;
  localparam upc_t PC_INV_TEST    = 6'd18;
  localparam upc_t PC_INV_CHK     = 6'd19;
  localparam upc_t PC_INV_STEP    = 6'd20;
  localparam upc_t PC_INV_END     = 6'd26;
  localparam upc_t PC_LAMBDA      = 6'd27;
  localparam upc_t PC_PT_END      = 6'd34;
  localparam upc_t PC_READ        = 6'd35;

  function automatic uop_t mk(op_t op, reg_t dst, reg_t s1, reg_t s2, ext_t ext, logic k);
    uop_t u;
    u.op  = op;
    u.dst = dst;
    u.s1  = s1;
    u.s2  = s2;
    u.ext = ext;
    u.k   = k;
    return u;
  endfunction

  function automatic uop_t ucode(upc_t pc);
    uop_t u;
    u = mk(OP_NOP, R_X1, R_X1, R_X1, EXT_X, 1'b0);
    case (pc)
      6'd0:  u = mk(OP_RED, R_QX,  R_X1,  R_X1,  EXT_X, 1'b0);
      6'd1:  u = mk(OP_RED, R_QY,  R_X1,  R_X1,  EXT_Y, 1'b0);
      6'd2:  u = mk(OP_RED, R_A,   R_X1,  R_X1,  EXT_A, 1'b0);
      // accumulator at infinity: copy addend
      6'd3:  u = mk(OP_MOV, R_X1,  R_QSX, R_QSX, EXT_X, 1'b0);
      6'd4:  u = mk(OP_MOV, R_Y1,  R_QSY, R_QSY, EXT_X, 1'b0);
      6'd5:  u = mk(OP_CMP, R_X1,  R_X1,  R_QSX, EXT_X, 1'b0);
      6'd6:  u = mk(OP_CMP, R_X1,  R_Y1,  R_QSY, EXT_X, 1'b0);
      // tangent slope: (3x^2 + a) / 2y
      6'd7:  u = mk(OP_MUL, R_TMP, R_X1,  R_X1,  EXT_X, 1'b0);
      6'd8:  u = mk(OP_ADD, R_NUM, R_TMP, R_TMP, EXT_X, 1'b0);
      6'd9:  u = mk(OP_ADD, R_NUM, R_NUM, R_TMP, EXT_X, 1'b0);
      6'd10: u = mk(OP_ADD, R_NUM, R_NUM, R_A,   EXT_X, 1'b0);
      6'd11: u = mk(OP_ADD, R_DEN, R_Y1,  R_Y1,  EXT_X, 1'b0);
      // chord slope
      6'd12: u = mk(OP_SUB, R_NUM, R_QSY, R_Y1,  EXT_X, 1'b0);
      6'd13: u = mk(OP_SUB, R_DEN, R_QSX, R_X1,  EXT_X, 1'b0);
      // extended Euclid, cofactors kept mod p
      6'd14: u = mk(OP_LDP, R_U,   R_X1,  R_X1,  EXT_X, 1'b0);
      6'd15: u = mk(OP_MOV, R_V,   R_DEN, R_DEN, EXT_X, 1'b0);
      6'd16: u = mk(OP_LDK, R_T0,  R_X1,  R_X1,  EXT_X, 1'b0);
      6'd17: u = mk(OP_LDK, R_T1,  R_X1,  R_X1,  EXT_X, 1'b1);
      6'd18: u = mk(OP_CMP, R_X1,  R_V,   R_V,   EXT_X, 1'b0);
      6'd19: u = mk(OP_CMP, R_X1,  R_U,   R_U,   EXT_X, 1'b0);
      6'd20: u = mk(OP_DIV, R_Q,   R_U,   R_V,   EXT_X, 1'b0);
      6'd21: u = mk(OP_MUL, R_TMP, R_Q,   R_T1,  EXT_X, 1'b0);
      6'd22: u = mk(OP_MOV, R_U,   R_V,   R_V,   EXT_X, 1'b0);
      6'd23: u = mk(OP_MVR, R_V,   R_X1,  R_X1,  EXT_X, 1'b0);
      6'd24: u = mk(OP_SUB, R_TMP, R_T0,  R_TMP, EXT_X, 1'b0);
      6'd25: u = mk(OP_MOV, R_T0,  R_T1,  R_T1,  EXT_X, 1'b0);
      6'd26: u = mk(OP_MOV, R_T1,  R_TMP, R_TMP, EXT_X, 1'b0);
      // new point
      6'd27: u = mk(OP_MUL, R_LAM, R_NUM, R_T0,  EXT_X, 1'b0);
      6'd28: u = mk(OP_MUL, R_TMP, R_LAM, R_LAM, EXT_X, 1'b0);
      6'd29: u = mk(OP_SUB, R_TMP, R_TMP, R_X1,  EXT_X, 1'b0);
      6'd30: u = mk(OP_SUB, R_TMP, R_TMP, R_QSX, EXT_X, 1'b0);
      6'd31: u = mk(OP_SUB, R_NUM, R_X1,  R_TMP, EXT_X, 1'b0);
      6'd32: u = mk(OP_MUL, R_NUM, R_LAM, R_NUM, EXT_X, 1'b0);
      6'd33: u = mk(OP_SUB, R_Y1,  R_NUM, R_Y1,  EXT_X, 1'b0);
      6'd34: u = mk(OP_MOV, R_X1,  R_TMP, R_TMP, EXT_X, 1'b0);
      6'd35: u = mk(OP_CMP, R_X1,  R_X1,  R_Y1,  EXT_X, 1'b0);
      default: u = mk(OP_NOP, R_X1, R_X1, R_X1, EXT_X, 1'b0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ecspm_dp.sv -----
// Datapath: 16-entry register file, serial modular multiplier and divider,
// combinational modular add/sub/compare. Depends on ecspm_pkg.
`default_nettype none

module ecspm_dp #(
  parameter int FIELD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ecspm_pkg::uop_t       cmd,
  input  wire logic                  cmd_valid,
  input  wire logic [FIELD_BITS-1:0] prime,
  input  wire logic [FIELD_BITS-1:0] coeff_a,
  input  wire logic [FIELD_BITS-1:0] ext_x,
  input  wire logic [FIELD_BITS-1:0] ext_y,
  output ecspm_pkg::dp_stat_t        stat,
  output logic [FIELD_BITS-1:0]      rd_a,
  output logic [FIELD_BITS-1:0]      rd_b
);

  localparam int W  = FIELD_BITS;
  localparam int CW = $clog2(W);

  typedef enum logic [1:0] {D_IDLE = 2'b01, D_EX = 2'b10} ph_t;

  logic [W-1:0]        rf [16];
  ph_t                 ph_r, ph_nxt;
  ecspm_pkg::op_t      op_r;
  ecspm_pkg::reg_t     dst_r;
  logic                k_r;
  logic [W-1:0]        a_r, b_r, ext_r;
  logic [CW-1:0]       cnt_r;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        quot_r, quot_nxt;
  logic                done_r, eq_r, zero_r, one_r;

  logic [CW-1:0]       idx;
  logic [W+1:0]        mt;
  logic [W-1:0]        dvd, dvs;
  logic [W:0]          r2, sum;
  logic                ge, multi, last, wen;
  logic [W-1:0]        add_res, sub_res, wb_res, ext_sel;

  always_comb begin
    case (cmd.ext)
      ecspm_pkg::EXT_X: ext_sel = ext_x;
      ecspm_pkg::EXT_Y: ext_sel = ext_y;
      default:          ext_sel = coeff_a;
    endcase
  end

  assign idx = CW'(W - 1) - cnt_r;

  // interleaved multiply: acc = 2*acc + bit*b, reduced below p
  assign mt = {1'b0, acc_r, 1'b0} + (a_r[idx] ? {2'b00, b_r} : '0);
  always_comb begin
    if (mt >= {1'b0, prime, 1'b0}) begin
      acc_nxt = W'(mt - {1'b0, prime, 1'b0});
    end else if (mt >= {2'b00, prime}) begin
      acc_nxt = W'(mt - {2'b00, prime});
    end else begin
      acc_nxt = W'(mt);
    end
  end

  // restoring division, one quotient bit per cycle
  assign dvd = (op_r == ecspm_pkg::OP_RED) ? ext_r : a_r;
  assign dvs = (op_r == ecspm_pkg::OP_RED) ? prime : b_r;
  assign r2  = {rem_r, dvd[idx]};
  assign ge  = (r2 >= {1'b0, dvs});
  assign rem_nxt  = ge ? W'(r2 - {1'b0, dvs}) : W'(r2);
  assign quot_nxt = {quot_r[W-2:0], ge};

  assign sum = {1'b0, a_r} + {1'b0, b_r};
  assign add_res = (sum >= {1'b0, prime}) ? W'(sum - {1'b0, prime}) : W'(sum);
  assign sub_res = (a_r >= b_r) ? (a_r - b_r)
                                : W'({1'b0, a_r} + {1'b0, prime} - {1'b0, b_r});

  assign multi = (op_r == ecspm_pkg::OP_MUL) || (op_r == ecspm_pkg::OP_DIV) ||
                 (op_r == ecspm_pkg::OP_RED);
  assign last  = !multi || (cnt_r == CW'(W - 1));

  always_comb begin
    wen = (ph_r == D_EX) && last;
    case (op_r)
      ecspm_pkg::OP_RED: wb_res = rem_nxt;
      ecspm_pkg::OP_DIV: wb_res = quot_nxt;
      ecspm_pkg::OP_MUL: wb_res = acc_nxt;
      ecspm_pkg::OP_MOV: wb_res = a_r;
      ecspm_pkg::OP_MVR: wb_res = rem_r;
      ecspm_pkg::OP_LDK: wb_res = W'(k_r);
      ecspm_pkg::OP_LDP: wb_res = prime;
      ecspm_pkg::OP_ADD: wb_res = add_res;
      ecspm_pkg::OP_SUB: wb_res = sub_res;
      default: begin
        wb_res = a_r;
        wen    = 1'b0;
      end
    endcase
  end

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      D_IDLE: if (cmd_valid) ph_nxt = D_EX;
      D_EX:   if (last) ph_nxt = D_IDLE;
      default: ph_nxt = D_IDLE;
    endcase
  end

  // register file
  always_ff @(posedge clk) begin
    if (wen) begin
      rf[dst_r] <= wb_res;
    end
    if (cmd_valid) begin
      a_r <= rf[cmd.s1];
      b_r <= rf[cmd.s2];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid) begin
      op_r   <= cmd.op;
      dst_r  <= cmd.dst;
      k_r    <= cmd.k;
      ext_r  <= ext_sel;
      acc_r  <= '0;
      quot_r <= '0;
      if (cmd.op == ecspm_pkg::OP_RED || cmd.op == ecspm_pkg::OP_DIV) begin
        rem_r <= '0;
      end
    end else if (ph_r == D_EX) begin
      acc_r  <= acc_nxt;
      quot_r <= quot_nxt;
      if (op_r == ecspm_pkg::OP_RED || op_r == ecspm_pkg::OP_DIV) begin
        rem_r <= rem_nxt;
      end
    end
    if (ph_r == D_EX && last) begin
      eq_r   <= (a_r == b_r);
      zero_r <= (a_r == '0);
      one_r  <= (a_r == W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= D_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == D_EX) && last;
      if (cmd_valid || last) begin
        cnt_r <= '0;
      end else if (ph_r == D_EX) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign stat.done   = done_r;
  assign stat.eq     = eq_r;
  assign stat.a_zero = zero_r;
  assign stat.a_one  = one_r;
  assign rd_a = a_r;
  assign rd_b = b_r;

endmodule

`default_nettype wire

// ----- hdl/ecspm_ctrl.sv -----
// Controller: scalar bit loop, micro-program sequencer and special cases.
// Depends on ecspm_pkg; drives ecspm_dp through uop_t commands.
`default_nettype none

module ecspm_ctrl #(
  parameter int SCALAR_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [SCALAR_BITS-1:0] start_scalar,
  input  wire logic                   p_small,
  output logic                        idle,
  output ecspm_pkg::uop_t             cmd,
  output logic                        cmd_valid,
  input  wire ecspm_pkg::dp_stat_t    stat,
  output logic                        res_valid,
  input  wire logic                   res_take,
  output logic                        res_inf,
  output logic                        res_err
);

  localparam int NW = $clog2(SCALAR_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOP  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_WAIT  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  ecspm_pkg::upc_t         pc_r, pc_nxt;
  logic [SCALAR_BITS-1:0]  shift_r, shift_nxt;
  logic [NW-1:0]           cnt_r, cnt_nxt;
  logic                    inf_r, inf_nxt, err_r, err_nxt;
  logic                    dbl_r, dbl_nxt, qsel_r, qsel_nxt;
  logic                    ret, bit_c;
  ecspm_pkg::uop_t         u;

  function automatic ecspm_pkg::reg_t map_reg(ecspm_pkg::reg_t r, logic addend);
    ecspm_pkg::reg_t m;
    case (r)
      ecspm_pkg::R_QSX: m = addend ? ecspm_pkg::R_QX : ecspm_pkg::R_X1;
      ecspm_pkg::R_QSY: m = addend ? ecspm_pkg::R_QY : ecspm_pkg::R_Y1;
      default:          m = r;
    endcase
    return m;
  endfunction

  always_comb begin
    u       = ecspm_pkg::ucode(pc_r);
    cmd     = u;
    cmd.s1  = map_reg(u.s1, qsel_r);
    cmd.s2  = map_reg(u.s2, qsel_r);
  end

  assign bit_c = shift_r[SCALAR_BITS-1];

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    inf_nxt   = inf_r;
    err_nxt   = err_r;
    dbl_nxt   = dbl_r;
    qsel_nxt  = qsel_r;
    ret       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          shift_nxt = start_scalar;
          cnt_nxt   = '0;
          inf_nxt   = 1'b1;
          err_nxt   = p_small;
          dbl_nxt   = 1'b0;
          qsel_nxt  = 1'b0;
          pc_nxt    = ecspm_pkg::PC_INIT;
          state_nxt = p_small ? S_FIN : S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (stat.done) begin
          state_nxt = S_ISSUE;
          pc_nxt    = pc_r + 1'b1;
          case (pc_r)
            ecspm_pkg::PC_LAST_INIT: state_nxt = S_LOOP;
            ecspm_pkg::PC_ADD_INF_END: begin
              inf_nxt = 1'b0;
              ret     = 1'b1;
            end
            ecspm_pkg::PC_CMP_X: if (!stat.eq) pc_nxt = ecspm_pkg::PC_ADD;
            ecspm_pkg::PC_CMP_Y: begin
              if (!stat.eq || stat.a_zero) begin
                inf_nxt = 1'b1;
                ret     = 1'b1;
              end
            end
            ecspm_pkg::PC_DBL_END:  pc_nxt = ecspm_pkg::PC_INV;
            ecspm_pkg::PC_INV_TEST: if (!stat.a_zero) pc_nxt = ecspm_pkg::PC_INV_STEP;
            ecspm_pkg::PC_INV_CHK: begin
              if (stat.a_one) begin
                pc_nxt = ecspm_pkg::PC_LAMBDA;
              end else begin
                err_nxt   = 1'b1;
                state_nxt = S_FIN;
              end
            end
            ecspm_pkg::PC_INV_END: pc_nxt = ecspm_pkg::PC_INV_TEST;
            ecspm_pkg::PC_PT_END:  ret = 1'b1;
            ecspm_pkg::PC_READ:    state_nxt = S_FIN;
            default: ;
          endcase
          if (ret) begin
            dbl_nxt = 1'b0;
            if (dbl_r && bit_c) begin
              qsel_nxt  = 1'b1;
              pc_nxt    = inf_nxt ? ecspm_pkg::PC_ADD_INF : ecspm_pkg::PC_CMP_X;
              state_nxt = S_ISSUE;
            end else begin
              shift_nxt = {shift_r[SCALAR_BITS-2:0], 1'b0};
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_LOOP;
            end
          end
        end
      end
      S_LOOP: begin
        if (cnt_r == NW'(SCALAR_BITS)) begin
          pc_nxt    = ecspm_pkg::PC_READ;
          state_nxt = S_ISSUE;
        end else if (!inf_r) begin
          dbl_nxt   = 1'b1;
          qsel_nxt  = 1'b0;
          pc_nxt    = ecspm_pkg::PC_CMP_X;
          state_nxt = S_ISSUE;
        end else if (bit_c) begin
          dbl_nxt   = 1'b0;
          qsel_nxt  = 1'b1;
          pc_nxt    = ecspm_pkg::PC_ADD_INF;
          state_nxt = S_ISSUE;
        end else begin
          shift_nxt = {shift_r[SCALAR_BITS-2:0], 1'b0};
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_FIN: if (res_take) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= ecspm_pkg::PC_INIT;
      shift_r <= '0;
      cnt_r   <= '0;
      inf_r   <= 1'b1;
      err_r   <= 1'b0;
      dbl_r   <= 1'b0;
      qsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      inf_r   <= inf_nxt;
      err_r   <= err_nxt;
      dbl_r   <= dbl_nxt;
      qsel_r  <= qsel_nxt;
    end
  end

  assign idle      = (state_r == S_IDLE);
  assign cmd_valid = (state_r == S_ISSUE);
  assign res_valid = (state_r == S_FIN);
  assign res_inf   = inf_r && !err_r;
  assign res_err   = err_r;

endmodule

`default_nettype wire

// ----- hdl/ec_scalar_point_multiply.sv -----
// EC scalar point multiply over GF(p), double-and-add, affine coordinates.
// Each field op is one micro-op; multiply, divide and reduce are bit-serial, the others
// combinational. One word is processed at a time: in_ready is high only while idle, and
// all micro-ops run in turn on the single shared datapath. Sync active-low reset;
// coefficient a resets to 1, prime to 41. Depends on ecspm_pkg, ecspm_ctrl, ecspm_dp.
`default_nettype none

module ec_scalar_point_multiply #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ecspm_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ecspm_pkg::out_word_t      out_data,
  input  wire logic                 cfg_psel,
  input  wire logic                 cfg_penable,
  input  wire logic                 cfg_pwrite,
  input  wire logic [2:0]           cfg_paddr,
  input  wire logic [31:0]          cfg_pwdata,
  output logic [31:0]               cfg_prdata,
  output logic                      cfg_pready
);

  localparam int W = FIELD_BITS;

  logic [W-1:0]          coeff_a_r, prime_r;
  ecspm_pkg::in_word_t   in_word_r;
  ecspm_pkg::out_word_t  out_word_r;
  logic                  out_valid_r;
  logic                  cfg_wr, start, idle, res_valid, res_take, res_inf, res_err;
  logic                  cmd_valid;
  ecspm_pkg::uop_t       cmd;
  ecspm_pkg::dp_stat_t   stat;
  logic [W-1:0]          rd_a, rd_b;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = cfg_paddr[2] ? 32'(prime_r) : 32'(coeff_a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_a_r <= W'(1);
      prime_r   <= W'(41);
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        prime_r <= W'(cfg_pwdata);
      end else begin
        coeff_a_r <= W'(cfg_pwdata);
      end
    end
  end

  assign in_ready = idle;
  assign start    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (start) begin
      in_word_r <= in_data;
    end
  end

  ecspm_ctrl #(
    .SCALAR_BITS(SCALAR_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .start_scalar (SCALAR_BITS'(in_data.scalar)),
    .p_small      (prime_r < W'(3)),
    .idle         (idle),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .stat         (stat),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res_inf      (res_inf),
    .res_err      (res_err)
  );

  ecspm_dp #(
    .FIELD_BITS(FIELD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .prime     (prime_r),
    .coeff_a   (coeff_a_r),
    .ext_x     (W'(in_word_r.base_x)),
    .ext_y     (W'(in_word_r.base_y)),
    .stat      (stat),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r.result_x      <= (res_inf || res_err) ? '0 : ecspm_pkg::WordBits'(rd_a);
      out_word_r.result_y      <= (res_inf || res_err) ? '0 : ecspm_pkg::WordBits'(rd_b);
      out_word_r.at_infinity   <= res_inf;
      out_word_r.inverse_error <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.at_infinity && out_data.inverse_error))
    else $error("infinity and inverse error both set");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.at_infinity || out_data.inverse_error)) |->
      (out_data.result_x == '0 && out_data.result_y == '0))
    else $error("nonzero coordinates on special result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while busy");

endmodule

`default_nettype wire
